[rtl/svau_pkg.sv]
// ----------------------------------------------------------------------------
// svau_pkg
// Shared types, constants and helpers for the voice allocator
// ----------------------------------------------------------------------------
package svau_pkg;

  localparam int unsigned NUM_VOICES = 16;
  localparam int unsigned VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned VOICE_OUT_W = 4;

  localparam logic REQ_PLAY  = 1'b0;
  localparam logic REQ_STOP  = 1'b1;
  localparam logic EVT_START = 1'b0;
  localparam logic EVT_STOP  = 1'b1;

  localparam logic [NOTE_W-1:0] NOTE_NONE = '0;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [NOTE_W-1:0]  note;
  } slot_t;

  typedef struct packed {
    logic              play;
    logic              stop;
    logic [NOTE_W-1:0] note;
  } cmd_t;

  function automatic logic [VOICE_OUT_W-1:0] voice_field(input logic [VOICE_W-1:0] v);
    logic [VOICE_W+VOICE_OUT_W-1:0] ext;
    ext = {{VOICE_OUT_W{1'b0}}, v};
    return ext[VOICE_OUT_W-1:0];
  endfunction

endpackage

[rtl/svau_cell.sv]
// ----------------------------------------------------------------------------
// svau_cell
// One list position: holds a voice and its note, shifts with its neighbors
// ----------------------------------------------------------------------------
module svau_cell
  import svau_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [svau_pkg::VOICE_W-1:0] rst_voice_i,
  input  svau_pkg::cmd_t             cmd_i,
  input  svau_pkg::slot_t            left_i,
  input  svau_pkg::slot_t            right_i,
  input  logic [svau_pkg::VOICE_W-1:0] ins_voice_i,
  input  logic                       hit_i,
  input  logic [svau_pkg::VOICE_W-1:0] hit_voice_i,
  output svau_pkg::slot_t            slot_o,
  output logic                       hit_o,
  output logic [svau_pkg::VOICE_W-1:0] hit_voice_o
);

  slot_t slot_q, slot_d;
  logic  match;
  logic  first;

  assign match       = cmd_i.stop && (slot_q.note == cmd_i.note);
  assign first       = match && !hit_i;
  assign hit_o       = hit_i || match;
  assign hit_voice_o = first ? slot_q.voice : hit_voice_i;
  assign slot_o      = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.play) begin
      slot_d = left_i;
    end else if (cmd_i.stop && hit_o && (slot_q.note != NOTE_NONE)) begin
      if (right_i.note != NOTE_NONE) begin
        slot_d = right_i;
      end else begin
        slot_d.voice = ins_voice_i;
        slot_d.note  = NOTE_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.voice <= rst_voice_i;
      slot_q.note  <= NOTE_NONE;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

[rtl/synth_voice_allocator_unit.sv]
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit
// LRU voice allocator built as a row of list cells
// ----------------------------------------------------------------------------
// output: a result is loaded into the output register in the cycle after its item is accepted
// throughput: one item per cycle while the output register is empty or being read;
//   the whole cell row updates together, bounded by the match chain that runs along the row
// reset: list positions hold voices in descending order, all voices idle,
//   output register empty
module synth_voice_allocator_unit
  import svau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // note[6:0], zero pad
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // voice[3:0], note_res[10:4], zero pad
  output logic        m_axis_tuser    // event_res
);

  slot_t              slot    [NUM_VOICES];
  logic               hit     [NUM_VOICES+1];
  logic [VOICE_W-1:0] hit_v   [NUM_VOICES+1];
  cmd_t               cmd;
  logic               in_acc;
  logic [NOTE_W-1:0]  nt;
  logic               found;
  logic [VOICE_W-1:0] last_voice;
  logic [VOICE_W-1:0] found_voice;

  logic                   out_valid_q, out_valid_d;
  logic                   out_evt_q, out_evt_d;
  logic [VOICE_OUT_W-1:0] out_voice_q, out_voice_d;
  logic [NOTE_W-1:0]      out_note_q, out_note_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign nt            = s_axis_tdata[NOTE_W-1:0];

  assign cmd.play = in_acc && (s_axis_tuser == REQ_PLAY) && (nt != NOTE_NONE);
  assign cmd.stop = in_acc && (s_axis_tuser == REQ_STOP) && (nt != NOTE_NONE);
  assign cmd.note = nt;

  assign hit[0]      = 1'b0;
  assign hit_v[0]    = '0;
  assign found       = hit[NUM_VOICES];
  assign found_voice = hit_v[NUM_VOICES];
  assign last_voice  = slot[NUM_VOICES-1].voice;

  for (genvar p = 0; p < NUM_VOICES; p++) begin : g_cell
    slot_t left, right;
    if (p == 0) begin : g_front
      assign left.voice = last_voice;
      assign left.note  = nt;
    end else begin : g_mid
      assign left = slot[p-1];
    end
    if (p == NUM_VOICES - 1) begin : g_back
      assign right = '0;
    end else begin : g_inner
      assign right = slot[p+1];
    end

    svau_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rst_voice_i (VOICE_W'(NUM_VOICES - 1 - p)),
      .cmd_i       (cmd),
      .left_i      (left),
      .right_i     (right),
      .ins_voice_i (found_voice),
      .hit_i       (hit[p]),
      .hit_voice_i (hit_v[p]),
      .slot_o      (slot[p]),
      .hit_o       (hit[p+1]),
      .hit_voice_o (hit_v[p+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_evt_d   = out_evt_q;
    out_voice_d = out_voice_q;
    out_note_d  = out_note_q;
    if (cmd.play) begin
      out_valid_d = 1'b1;
      out_evt_d   = EVT_START;
      out_voice_d = voice_field(last_voice);
      out_note_d  = nt;
    end else if (cmd.stop && found) begin
      out_valid_d = 1'b1;
      out_evt_d   = EVT_STOP;
      out_voice_d = voice_field(found_voice);
      out_note_d  = NOTE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_evt_q   <= out_evt_d;
    out_voice_q <= out_voice_d;
    out_note_q  <= out_note_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_evt_q;
  assign m_axis_tdata  = {5'b0, out_note_q, out_voice_q};

endmodule

[tb/voice_alloc_checker.sv]
// ----------------------------------------------------------------------------
// voice_alloc_checker
// Tracks the LRU voice list from the accepted requests and compares every
// voice start and release on the output stream against its own prediction
// ----------------------------------------------------------------------------
module voice_alloc_checker
  import svau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,    // note[6:0], zero pad
  input  logic        in_kind_i,    // req_type
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,   // voice[3:0], note_res[10:4], zero pad
  input  logic        out_evt_i,    // event_res
  output int          fail_count_o,
  output int          predicted_o,
  output int          pending_o,
  output int          steal_count_o,
  output int          stop_count_o
);

  typedef struct packed {
    logic                   evt;
    logic [VOICE_OUT_W-1:0] voice;
    logic [NOTE_W-1:0]      note;
  } voice_evt_t;

  logic [VOICE_W-1:0] list_voice [NUM_VOICES];
  logic [NOTE_W-1:0]  list_note  [NUM_VOICES];
  voice_evt_t         evt_q [$];
  int n_fail      = 0;
  int n_predicted = 0;
  int n_steal     = 0;
  int n_stop      = 0;

  assign fail_count_o  = n_fail;
  assign steal_count_o = n_steal;
  assign stop_count_o  = n_stop;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    voice_evt_t         want;
    logic [VOICE_W-1:0] v;
    logic [NOTE_W-1:0]  nt;
    int                 hit;
    int                 act;
    if (!rst_ni) begin
      for (int p = 0; p < NUM_VOICES; p++) begin
        list_voice[p] = VOICE_W'(NUM_VOICES - 1 - p);
        list_note[p]  = NOTE_NONE;
      end
      evt_q.delete();
      pending_o   <= 0;
      predicted_o <= 0;
    end else begin
      // results leave before the item taken at this edge can produce one
      if (out_valid_i && out_ready_i) begin
        if (evt_q.size() == 0) begin
          report_mismatch("result with none waiting, data", 0, out_data_i);
        end else begin
          want = evt_q.pop_front();
          if (out_evt_i !== want.evt)
            report_mismatch("event_res", want.evt, out_evt_i);
          if (out_data_i[3:0] !== want.voice)
            report_mismatch("voice", want.voice, out_data_i[3:0]);
          if (out_data_i[10:4] !== want.note)
            report_mismatch("note_res", want.note, out_data_i[10:4]);
          if (out_data_i[15:11] !== 5'd0)
            report_mismatch("tdata pad", 0, out_data_i[15:11]);
        end
      end

      if (in_valid_i && in_ready_i) begin
        nt = in_data_i[NOTE_W-1:0];
        if (nt != NOTE_NONE) begin
          if (in_kind_i == REQ_PLAY) begin
            // tail slot moves to the front, stolen if still sounding
            v = list_voice[NUM_VOICES-1];
            if (list_note[NUM_VOICES-1] != NOTE_NONE) n_steal++;
            for (int p = NUM_VOICES - 1; p > 0; p--) begin
              list_voice[p] = list_voice[p-1];
              list_note[p]  = list_note[p-1];
            end
            list_voice[0] = v;
            list_note[0]  = nt;
            evt_q.push_back('{EVT_START, VOICE_OUT_W'(v), nt});
            n_predicted++;
          end else begin
            hit = -1;
            act = NUM_VOICES;
            for (int p = 0; p < NUM_VOICES; p++) begin
              if (list_note[p] == NOTE_NONE) begin
                act = p;
                break;
              end
              if (hit < 0 && list_note[p] == nt) hit = p;
            end
            // released voice goes to the head of the idle block
            if (hit >= 0) begin
              v = list_voice[hit];
              for (int p = hit; p < act - 1; p++) begin
                list_voice[p] = list_voice[p+1];
                list_note[p]  = list_note[p+1];
              end
              list_voice[act-1] = v;
              list_note[act-1]  = NOTE_NONE;
              evt_q.push_back('{EVT_STOP, VOICE_OUT_W'(v), NOTE_NONE});
              n_predicted++;
              n_stop++;
            end
          end
        end
      end
      pending_o   <= evt_q.size();
      predicted_o <= n_predicted;
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives note on and note off requests into the voice allocator with random
// gaps and output stalls; a side checker predicts and compares the results
// ----------------------------------------------------------------------------
module tb;
  import svau_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic no_gap  = 1'b0;
  int   n_items = 0;
  int   fail_count;
  int   predicted;
  int   pending;
  int   steal_count;
  int   stop_count;

  always #10 clk_i = ~clk_i;

  synth_voice_allocator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  voice_alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_kind_i     (s_axis_tuser),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_i    (m_axis_tdata),
    .out_evt_i     (m_axis_tuser),
    .fail_count_o  (fail_count),
    .predicted_o   (predicted),
    .pending_o     (pending),
    .steal_count_o (steal_count),
    .stop_count_o  (stop_count)
  );

  task automatic send_request(input logic kind, input logic [NOTE_W-1:0] nt);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 8'(nt);
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  initial begin
    logic              kind;
    logic [NOTE_W-1:0] nt;
    int                r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // note zero, unknown note, repeated note, extremes
    send_request(REQ_PLAY, NOTE_NONE);
    send_request(REQ_STOP, NOTE_NONE);
    send_request(REQ_STOP, 7'd5);
    send_request(REQ_PLAY, 7'd127);
    send_request(REQ_PLAY, 7'd1);
    send_request(REQ_PLAY, 7'd1);
    send_request(REQ_STOP, 7'd1);
    send_request(REQ_STOP, 7'd1);
    send_request(REQ_STOP, 7'd1);
    send_request(REQ_STOP, 7'd127);
    // fill every voice, then steal the oldest
    for (int i = 1; i <= NUM_VOICES + 1; i++) send_request(REQ_PLAY, NOTE_W'(i * 7));

    while (n_items < 600) begin
      r    = $urandom_range(0, 99);
      kind = (r < 55) ? REQ_PLAY : REQ_STOP;
      r    = $urandom_range(0, 99);
      if (r < 4)       nt = NOTE_NONE;
      else if (r < 75) nt = NOTE_W'($urandom_range(1, 20));
      else             nt = NOTE_W'($urandom_range(1, 127));
      send_request(kind, nt);
      if (n_items % 64 == 0) no_gap = ($urandom_range(0, 3) == 0);
    end
    s_axis_tvalid <= 1'b0;
    no_gap = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d requests giving %0d results", n_items, predicted);
    $display("  %0d releases, %0d voices stolen while all were busy", stop_count, steal_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_gap ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
